### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the servo packet framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// flag any edge at which cond holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared codes, constants and the burst descriptor of the servo packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package scpf_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] LEN_EXTRA  = 8'h02;
	localparam int         BURST_MAX  = 6;
	localparam int         BURST_CW   = $clog2(BURST_MAX + 1);

	typedef enum logic {
		OP_HEADER = 1'b0,
		OP_PARAM  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [BURST_CW-1:0]       count;
		logic                      port;
		logic                      closes;
	} burst_t;

endpackage

`default_nettype wire

### rtl/servo_command_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_command_packet_framer
// Frames servo command packets with an inverted byte-sum checksum.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per handshake: a header
// word (opcode 0) or a parameter word (opcode 1). A header emits FF FF id
// length instruction, plus the checksum when its count is zero; a parameter
// emits its byte, plus the checksum when it is the last one. Parameters with
// no open packet produce nothing; a header mid-packet abandons the open one.
// Output channel (out_valid/out_ready) carries one byte per handshake, with
// end_of_packet on the checksum and end_of_run on the last byte of a word.
// A word's first byte passes the burst register and then the output register.
// The shifter sends one output byte per cycle while the receiver keeps up; a
// header makes 5 or 6 bytes, a parameter 1 or 2 and a dropped word none,
// and the next word is taken in the cycle the last byte moves out.
// Reset clears the packet state and empties both stages. A stalled receiver
// holds the output byte; the shifter then holds and input backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_command_packet_framer #(
	parameter int MAX_PARAMS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       opcode,
	input  wire logic [7:0] servo_id,
	input  wire logic [7:0] instruction,
	input  wire logic [5:0] param_count,
	input  wire logic [7:0] param_byte,
	input  wire logic       port_select,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      tx_byte,
	output logic            tx_port,
	output logic            end_of_packet,
	output logic            end_of_run
);

	scpf_pkg::burst_t burst;
	logic             accept;

	assign accept = in_valid && in_ready;

	scpf_frame #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.servo_id   (servo_id),
		.instruction(instruction),
		.param_count(param_count),
		.param_byte (param_byte),
		.port_select(port_select),
		.burst      (burst)
	);

	scpf_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.load_ready   (in_ready),
		.burst        (burst),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tx_byte      (tx_byte),
		.tx_port      (tx_port),
		.end_of_packet(end_of_packet),
		.end_of_run   (end_of_run)
	);

endmodule

`default_nettype wire

### rtl/scpf_frame.sv
// ----------------------------------------------------------------------------
// scpf_frame
// Packet state and burst decode: turns one input word into its output bytes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scpf_frame #(
	parameter int MAX_PARAMS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  opcode,
	input  wire logic [7:0]            servo_id,
	input  wire logic [7:0]            instruction,
	input  wire logic [5:0]            param_count,
	input  wire logic [7:0]            param_byte,
	input  wire logic                  port_select,
	output scpf_pkg::burst_t           burst
);

	localparam int CW = (MAX_PARAMS >= 63) ? 6 : $clog2(MAX_PARAMS + 1);

	logic          packet_open_q;
	logic [CW-1:0] params_left_q;
	logic [7:0]    running_sum_q;
	logic          current_port_q;

	logic          open_d;
	logic [CW-1:0] left_d;
	logic [7:0]    sum_d;
	logic          port_d;
	logic [5:0]    count_sat;
	logic [7:0]    len;
	logic [CW-1:0] left_dec;
	logic [7:0]    sum_param;

	always_comb begin
		if ({2'b00, param_count} > 8'(MAX_PARAMS)) begin
			count_sat = 6'(MAX_PARAMS);
		end else begin
			count_sat = param_count;
		end
		len       = {2'b00, count_sat} + scpf_pkg::LEN_EXTRA;
		left_dec  = params_left_q - CW'(1);
		sum_param = running_sum_q + param_byte;

		open_d       = packet_open_q;
		left_d       = params_left_q;
		sum_d        = running_sum_q;
		port_d       = current_port_q;
		burst        = '0;
		burst.port   = current_port_q;

		if (opcode == scpf_pkg::OP_HEADER) begin
			sum_d          = servo_id + len + instruction;
			port_d         = port_select;
			burst.port     = port_select;
			burst.bytes[0] = scpf_pkg::START_BYTE;
			burst.bytes[1] = scpf_pkg::START_BYTE;
			burst.bytes[2] = servo_id;
			burst.bytes[3] = len;
			burst.bytes[4] = instruction;
			burst.bytes[5] = ~sum_d;
			if (count_sat == 6'd0) begin
				open_d       = 1'b0;
				left_d       = '0;
				burst.count  = scpf_pkg::BURST_CW'(6);
				burst.closes = 1'b1;
			end else begin
				open_d      = 1'b1;
				left_d      = CW'(count_sat);
				burst.count = scpf_pkg::BURST_CW'(5);
			end
		end else if (packet_open_q && params_left_q != '0) begin
			sum_d          = sum_param;
			left_d         = left_dec;
			burst.bytes[0] = param_byte;
			burst.bytes[1] = ~sum_param;
			if (left_dec == '0) begin
				open_d       = 1'b0;
				burst.count  = scpf_pkg::BURST_CW'(2);
				burst.closes = 1'b1;
			end else begin
				burst.count = scpf_pkg::BURST_CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_open_q  <= 1'b0;
			params_left_q  <= '0;
			running_sum_q  <= '0;
			current_port_q <= 1'b0;
		end else if (accept) begin
			packet_open_q  <= open_d;
			params_left_q  <= left_d;
			running_sum_q  <= sum_d;
			current_port_q <= port_d;
		end
	end

	`ASSERT_CLK(a_open_matches_left, clk, arst_n, packet_open_q == (params_left_q != '0), "open flag disagrees with parameter count")
	`ASSERT_CLK(a_drop_keeps_sum, clk, arst_n, accept && opcode == scpf_pkg::OP_PARAM && !packet_open_q |=> $stable(running_sum_q) && !packet_open_q, "dropped word changed packet state")

endmodule

`default_nettype wire

### rtl/scpf_serial.sv
// ----------------------------------------------------------------------------
// scpf_serial
// Burst register and byte shifter feeding the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scpf_serial (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  load_ready,
	input  wire scpf_pkg::burst_t burst,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            tx_byte,
	output logic                  tx_port,
	output logic                  end_of_packet,
	output logic                  end_of_run
);

	localparam int N  = scpf_pkg::BURST_MAX;
	localparam int CW = scpf_pkg::BURST_CW;

	logic [N-1:0][7:0] sh_s1;
	logic [CW-1:0]     cnt_s1;
	logic              port_s1;
	logic              closes_s1;

	logic              out_valid_s2;
	logic [7:0]        tx_byte_s2;
	logic              tx_port_s2;
	logic              eop_s2;
	logic              eor_s2;

	logic              out_free;
	logic              move;
	logic              last;
	logic              load;

	assign out_free   = !out_valid_s2 || out_ready;
	assign move       = (cnt_s1 != '0) && out_free;
	assign last       = (cnt_s1 == CW'(1));
	assign load_ready = (cnt_s1 == '0) || (last && out_free);
	assign load       = in_valid && load_ready && (burst.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (load) begin
			cnt_s1 <= burst.count;
		end else if (move) begin
			cnt_s1 <= cnt_s1 - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_s1     <= burst.bytes;
			port_s1   <= burst.port;
			closes_s1 <= burst.closes;
		end else if (move) begin
			sh_s1 <= {8'h00, sh_s1[N-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (move) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			tx_byte_s2 <= sh_s1[0];
			tx_port_s2 <= port_s1;
			eop_s2     <= closes_s1 && last;
			eor_s2     <= last;
		end
	end

	assign out_valid     = out_valid_s2;
	assign tx_byte       = tx_byte_s2;
	assign tx_port       = tx_port_s2;
	assign end_of_packet = eop_s2;
	assign end_of_run    = eor_s2;

	`ASSERT_CLK(a_cnt_range, clk, arst_n, cnt_s1 <= CW'(N), "burst count out of range")
	`ASSERT_CLK(a_eop_closes_run, clk, arst_n, out_valid_s2 && eop_s2 |-> eor_s2, "packet end without run end")

endmodule

`default_nettype wire
